// ===== hdl/rsi_pkg.sv =====
// Shared types and register codes for the ray/sphere intersection pipeline.
`timescale 1ns / 1ps
package rsi_pkg;

	// Control flags that travel alongside each ray through the pipeline
	typedef struct packed {
		logic vld;
		logic degen;
		logic miss;
		logic hit;
		logic neg;
		logic big;
	} rsi_ctl_t;

	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_CENTER_X      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z      = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPHERE_RADIUS = 2'd3;

endpackage

// ===== hdl/ray_sphere_intersection.sv =====
// Throughput: one ray per cycle while the output is not stalled; the sqrt chain
// (one cell per root bit) and the divider chain (one cell per quotient bit) each
// retire one step a cycle while not stalled.
// The whole pipeline holds while a result waits at the output and is not taken.
// Reset clears all valid flags and loads center 0, radius 1.0; cfg_ready is always high.
`timescale 1ns / 1ps
module ray_sphere_intersection import rsi_pkg::*; #(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS   = 16
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     s_axis_tvalid,
	output logic                                     s_axis_tready,
	// origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
	input  logic [((6*COORD_WIDTH+7)/8)*8-1:0]       s_axis_tdata,
	output logic                                     m_axis_tvalid,
	input  logic                                     m_axis_tready,
	// distance
	output logic [((COORD_WIDTH+7)/8)*8-1:0]         m_axis_tdata,
	// hit, degenerate
	output logic [1:0]                               m_axis_tuser,
	input  logic                                     cfg_valid,
	output logic                                     cfg_ready,
	input  logic [CFG_IDX_W-1:0]                     cfg_index,
	input  logic [COORD_WIDTH-1:0]                   cfg_data
);
	localparam int W    = COORD_WIDTH;
	localparam int F    = FRAC_BITS;
	localparam int DW   = W + 1;
	localparam int PW   = 2 * DW;
	localparam int AW   = 2 * W;
	localparam int N    = 2 * W + 3;
	localparam int EW   = 2 * N + 1;
	localparam int RW   = 2 * N;
	localparam int NB   = N + 2;
	localparam int DVW  = NB + F;
	localparam int RIW  = DVW - W;
	localparam int XW   = (RIW > AW) ? RIW : AW;
	localparam int SW   = N + AW;
	localparam int OTW  = ((W + 7) / 8) * 8;

	localparam logic [W-2:0] RAD_RST   = (W-1)'(1) << F;
	localparam logic [W-1:0] FONE      = W'(1) << F;
	localparam logic [W-1:0] MINUS_ONE = W'(0) - FONE;
	localparam logic [W-1:0] HALF      = W'(1) << (W - 1);

	logic en;

	// configuration registers
	logic [W-1:0] cx_q, cy_q, cz_q;
	logic [W-2:0] rad_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q  <= '0;
			cy_q  <= '0;
			cz_q  <= '0;
			rad_q <= RAD_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_CENTER_X:      cx_q  <= cfg_data;
				REG_CENTER_Y:      cy_q  <= cfg_data;
				REG_CENTER_Z:      cz_q  <= cfg_data;
				REG_SPHERE_RADIUS: rad_q <= cfg_data[W-2:0];
				default:           ;
			endcase
		end
	end

	logic [W-1:0] cen [3];
	assign cen[0] = cx_q;
	assign cen[1] = cy_q;
	assign cen[2] = cz_q;

	// stage 1: offsets from center
	rsi_ctl_t              ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5, ctl_s6;
	logic signed [DW-1:0]  d_s1 [3];
	logic signed [DW-1:0]  v_s1 [3];
	logic signed [PW-1:0]  vv_s2 [3];
	logic signed [PW-1:0]  vd_s2 [3];
	logic signed [PW-1:0]  dd_s2 [3];
	logic [AW-1:0]         rr_s2;
	logic [AW-1:0]         a_s3, a_s4, a_s5;
	logic signed [N-1:0]   h_s3, h_s4, h_s5;
	logic signed [N-1:0]   c_s3;
	logic                  cneg_s4, cneg_s5;
	logic [N-1:0]          hmag, cmag;
	logic [2*N-1:0]        hh_p, ac_p;
	logic [EW-1:0]         e_val;
	logic [RW-1:0]         rad_s6;
	logic [SW-1:0]         side_s6;
	rsi_ctl_t              ctl_s1_n, ctl_s4_n, ctl_s6_n;

	assign en            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	always_comb begin
		ctl_s1_n       = '0;
		ctl_s1_n.vld   = s_axis_tvalid;
		ctl_s4_n       = ctl_s3;
		ctl_s4_n.degen = (a_s3 == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
			ctl_s6 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_s1_n;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s4_n;
			ctl_s5 <= ctl_s4;
			ctl_s6 <= ctl_s6_n;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				d_s1[k] <= $signed({s_axis_tdata[k*W+W-1], s_axis_tdata[k*W +: W]})
					- $signed({cen[k][W-1], cen[k]});
				v_s1[k] <= $signed({s_axis_tdata[(3+k)*W+W-1], s_axis_tdata[(3+k)*W +: W]});
				vv_s2[k] <= v_s1[k] * v_s1[k];
				vd_s2[k] <= v_s1[k] * d_s1[k];
				dd_s2[k] <= d_s1[k] * d_s1[k];
			end
			rr_s2 <= AW'(rad_q) * AW'(rad_q);
			a_s3  <= AW'(N'(vv_s2[0]) + N'(vv_s2[1]) + N'(vv_s2[2]));
			h_s3  <= N'(vd_s2[0]) + N'(vd_s2[1]) + N'(vd_s2[2]);
			c_s3  <= N'(dd_s2[0]) + N'(dd_s2[1]) + N'(dd_s2[2]) - $signed(N'(rr_s2));
			a_s4    <= a_s3;
			h_s4    <= h_s3;
			cneg_s4 <= c_s3[N-1];
			a_s5    <= a_s4;
			h_s5    <= h_s4;
			cneg_s5 <= cneg_s4;
			rad_s6  <= e_val[EW-1] ? '0 : e_val[RW-1:0];
			side_s6 <= {h_s5, a_s5};
		end
	end

	assign hmag = h_s3[N-1] ? N'(-h_s3) : N'(h_s3);
	assign cmag = c_s3[N-1] ? N'(-c_s3) : N'(c_s3);

	rsi_mul #(.N(N)) u_mul_hh (
		.clk (clk),
		.en  (en),
		.a_i (hmag),
		.b_i (hmag),
		.p_o (hh_p)
	);

	rsi_mul #(.N(N)) u_mul_ac (
		.clk (clk),
		.en  (en),
		.a_i (N'(a_s3)),
		.b_i (cmag),
		.p_o (ac_p)
	);

	// quarter discriminant h*h - a*c
	always_comb begin
		e_val = cneg_s5 ? ({1'b0, hh_p} + {1'b0, ac_p}) : ({1'b0, hh_p} - {1'b0, ac_p});
		ctl_s6_n      = ctl_s5;
		ctl_s6_n.miss = e_val[EW-1];
		ctl_s6_n.hit  = !ctl_s5.degen && !e_val[EW-1] && (e_val != '0);
	end

	// square-root chain
	rsi_ctl_t          sq_ctl  [N+1];
	logic [RW-1:0]     sq_rad  [N+1];
	logic [N+1:0]      sq_rem  [N+1];
	logic [N-1:0]      sq_root [N+1];
	logic [SW-1:0]     sq_side [N+1];

	assign sq_ctl[0]  = ctl_s6;
	assign sq_rad[0]  = rad_s6;
	assign sq_rem[0]  = '0;
	assign sq_root[0] = '0;
	assign sq_side[0] = side_s6;

	for (genvar i = 0; i < N; i++) begin : g_sqrt
		rsi_sqrt_cell #(.RW(RW), .SW(SW)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.ctl_i  (sq_ctl[i]),
			.rad_i  (sq_rad[i]),
			.rem_i  (sq_rem[i]),
			.root_i (sq_root[i]),
			.side_i (sq_side[i]),
			.ctl_o  (sq_ctl[i+1]),
			.rad_o  (sq_rad[i+1]),
			.rem_o  (sq_rem[i+1]),
			.root_o (sq_root[i+1]),
			.side_o (sq_side[i+1])
		);
	end

	// stage 7: pick the root, stage 8: set up the division
	logic signed [NB-1:0] nh, t1, t2, tsel;
	rsi_ctl_t             ctl_s7, ctl_s8, ctl_s7_n, ctl_s8_n;
	logic [NB-1:0]        mag_s7;
	logic [AW-1:0]        a_s7, a_s8;
	logic [DVW-1:0]       dvd;
	logic [XW-1:0]        rem_wide;
	logic [AW-1:0]        rem_s8;
	logic [W-1:0]         low_s8;

	always_comb begin
		nh   = -NB'($signed(sq_side[N][SW-1:AW]));
		t1   = nh + $signed(NB'(sq_root[N]));
		t2   = nh - $signed(NB'(sq_root[N]));
		tsel = (!t1[NB-1] && (t1 != '0) && t2[NB-1]) ? t1 : t2;
		ctl_s7_n     = sq_ctl[N];
		ctl_s7_n.neg = tsel[NB-1];
		dvd      = {mag_s7, F'(0)};
		rem_wide = XW'(dvd >> W);
		ctl_s8_n     = ctl_s7;
		ctl_s8_n.big = (rem_wide >= XW'(a_s7));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s7 <= '0;
			ctl_s8 <= '0;
		end else if (en) begin
			ctl_s7 <= ctl_s7_n;
			ctl_s8 <= ctl_s8_n;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s7 <= tsel[NB-1] ? NB'(-tsel) : NB'(tsel);
			a_s7   <= sq_side[N][AW-1:0];
			a_s8   <= a_s7;
			rem_s8 <= rem_wide[AW-1:0];
			low_s8 <= dvd[W-1:0];
		end
	end

	// divider chain
	rsi_ctl_t        dv_ctl [W+1];
	logic [AW-1:0]   dv_div [W+1];
	logic [AW-1:0]   dv_rem [W+1];
	logic [W-1:0]    dv_dvd [W+1];
	logic [W-1:0]    dv_q   [W+1];

	assign dv_ctl[0] = ctl_s8;
	assign dv_div[0] = a_s8;
	assign dv_rem[0] = rem_s8;
	assign dv_dvd[0] = low_s8;
	assign dv_q[0]   = '0;

	for (genvar j = 0; j < W; j++) begin : g_div
		rsi_div_cell #(.AW(AW), .QW(W)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.ctl_i  (dv_ctl[j]),
			.div_i  (dv_div[j]),
			.rem_i  (dv_rem[j]),
			.dvd_i  (dv_dvd[j]),
			.q_i    (dv_q[j]),
			.ctl_o  (dv_ctl[j+1]),
			.div_o  (dv_div[j+1]),
			.rem_o  (dv_rem[j+1]),
			.dvd_o  (dv_dvd[j+1]),
			.q_o    (dv_q[j+1])
		);
	end

	// saturate and register the result
	rsi_ctl_t     fc;
	logic [W-1:0] qmag, dist_n;
	logic         out_vld_q, hit_q, deg_q;
	logic [W-1:0] dist_q;

	always_comb begin
		fc = dv_ctl[W];
		if (fc.neg) begin
			qmag = (fc.big || (dv_q[W] > HALF)) ? HALF : dv_q[W];
		end else begin
			qmag = (fc.big || dv_q[W][W-1]) ? (HALF - W'(1)) : dv_q[W];
		end
		if (fc.degen || fc.miss) begin
			dist_n = MINUS_ONE;
		end else begin
			dist_n = fc.neg ? (W'(0) - qmag) : qmag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= fc.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dist_q <= dist_n;
			hit_q  <= fc.hit;
			deg_q  <= fc.degen;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = OTW'(dist_q);
	assign m_axis_tuser  = {deg_q, hit_q};

	// a zero direction never reports a hit and always reports minus one
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[1]) |-> (!m_axis_tuser[0] && dist_q == MINUS_ONE))
		else $error("degenerate result with hit or wrong distance");

	// input side moves exactly when the output register can advance
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready == (!m_axis_tvalid || m_axis_tready))
		else $error("input ready out of step with output stall");

	// a negative discriminant never leaves the discriminant stage marked as a hit
	assert property (@(posedge clk) disable iff (!arst_n)
		(ctl_s6.vld && ctl_s6.miss) |-> (!ctl_s6.hit && rad_s6 == '0))
		else $error("miss flagged as hit or with nonzero radicand");

endmodule

// ===== hdl/rsi_mul.sv =====
// Two-stage unsigned multiplier built from four half-width partial products.
`timescale 1ns / 1ps
module rsi_mul import rsi_pkg::*; #(
	parameter int N = 67
) (
	input  logic             clk,
	input  logic             en,
	input  logic [N-1:0]     a_i,
	input  logic [N-1:0]     b_i,
	output logic [2*N-1:0]   p_o
);
	localparam int L = (N + 1) / 2;
	localparam int H = N - L;

	logic [2*L-1:0]   ll_s1;
	logic [L+H-1:0]   lh_s1;
	logic [L+H-1:0]   hl_s1;
	logic [2*H-1:0]   hh_s1;
	logic [2*N-1:0]   p_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			ll_s1 <= a_i[L-1:0] * b_i[L-1:0];
			lh_s1 <= a_i[L-1:0] * b_i[N-1:L];
			hl_s1 <= a_i[N-1:L] * b_i[L-1:0];
			hh_s1 <= a_i[N-1:L] * b_i[N-1:L];
			p_s2  <= ((2*N)'(hh_s1) << (2*L))
				+ (((2*N)'(lh_s1) + (2*N)'(hl_s1)) << L)
				+ (2*N)'(ll_s1);
		end
	end

	assign p_o = p_s2;

endmodule

// ===== hdl/rsi_sqrt_cell.sv =====
// One cell of the square-root chain: settles one root bit per cycle while en is high.
`timescale 1ns / 1ps
module rsi_sqrt_cell import rsi_pkg::*; #(
	parameter int RW = 134,
	parameter int SW = 131
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  rsi_ctl_t            ctl_i,
	input  logic [RW-1:0]       rad_i,
	input  logic [RW/2+1:0]     rem_i,
	input  logic [RW/2-1:0]     root_i,
	input  logic [SW-1:0]       side_i,
	output rsi_ctl_t            ctl_o,
	output logic [RW-1:0]       rad_o,
	output logic [RW/2+1:0]     rem_o,
	output logic [RW/2-1:0]     root_o,
	output logic [SW-1:0]       side_o
);
	localparam int SQB = RW / 2;
	localparam int RMW = SQB + 2;

	logic [RMW+1:0] sh;
	logic [RMW+1:0] trial;
	logic [RMW+1:0] diff;
	logic           ge;

	always_comb begin
		sh    = {rem_i, rad_i[RW-1 -: 2]};
		trial = (RMW+2)'({root_i, 2'b01});
		diff  = sh - trial;
		ge    = (sh >= trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_o <= '0;
		end else if (en) begin
			ctl_o <= ctl_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_o  <= ge ? diff[RMW-1:0] : sh[RMW-1:0];
			root_o <= {root_i[SQB-2:0], ge};
			rad_o  <= rad_i << 2;
			side_o <= side_i;
		end
	end

endmodule

// ===== hdl/rsi_div_cell.sv =====
// One cell of the divider chain: restoring step, one quotient bit per cycle while en is high.
`timescale 1ns / 1ps
module rsi_div_cell import rsi_pkg::*; #(
	parameter int AW = 64,
	parameter int QW = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  rsi_ctl_t        ctl_i,
	input  logic [AW-1:0]   div_i,
	input  logic [AW-1:0]   rem_i,
	input  logic [QW-1:0]   dvd_i,
	input  logic [QW-1:0]   q_i,
	output rsi_ctl_t        ctl_o,
	output logic [AW-1:0]   div_o,
	output logic [AW-1:0]   rem_o,
	output logic [QW-1:0]   dvd_o,
	output logic [QW-1:0]   q_o
);
	logic [AW:0] sh;
	logic [AW:0] diff;
	logic        ge;

	always_comb begin
		sh   = {rem_i, dvd_i[QW-1]};
		diff = sh - {1'b0, div_i};
		ge   = (sh >= {1'b0, div_i});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_o <= '0;
		end else if (en) begin
			ctl_o <= ctl_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_o <= ge ? diff[AW-1:0] : sh[AW-1:0];
			q_o   <= {q_i[QW-2:0], ge};
			dvd_o <= dvd_i << 1;
			div_o <= div_i;
		end
	end

endmodule
